>>> hw/rtl/gnps_pkg.sv
// shared types and constants of the gated nearest point search unit
package gnps_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned COORD_W        = 32;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned DIST_W         = 2 * COORD_W + 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    localparam logic [1:0] CFG_RANGE_MODE = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_Y_LIMIT    = 2'd2;

    localparam logic [COORD_W-1:0] LIMIT_RST = 32'd12000;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] point_index;
    } t_out_beat;

    typedef struct packed {
        logic vld;
        logic keep;
    } t_cand;

endpackage

>>> hw/rtl/gnps_dist_pipe.sv
// distance pipeline: absolute differences, axis gate, squares and their sum
module gnps_dist_pipe #(
    parameter int unsigned AW = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic [AW-1:0]                        i_idx,
    input  logic [gnps_pkg::COORD_W-1:0]         i_px,
    input  logic [gnps_pkg::COORD_W-1:0]         i_py,
    input  logic [gnps_pkg::COORD_W-1:0]         i_qx,
    input  logic [gnps_pkg::COORD_W-1:0]         i_qy,
    input  logic                                 i_range_mode,
    input  logic [gnps_pkg::COORD_W-1:0]         i_x_limit,
    input  logic [gnps_pkg::COORD_W-1:0]         i_y_limit,
    output gnps_pkg::t_cand                      o_tag,
    output logic [AW-1:0]                        o_idx,
    output logic [gnps_pkg::DIST_W-1:0]          o_dist,
    output logic                                 o_busy
);

    localparam int unsigned CW = gnps_pkg::COORD_W;

    logic [CW:0]          dxw;
    logic [CW:0]          dyw;
    logic [CW:0]          dxa;
    logic [CW:0]          dya;
    logic                 gate_hit;

    logic                 r_s1_vld;
    logic [AW-1:0]        r_s1_idx;
    logic [CW-1:0]        r_dx;
    logic [CW-1:0]        r_dy;

    logic                 r_s2_vld;
    logic                 r_s2_keep;
    logic [AW-1:0]        r_s2_idx;
    logic [2*CW-1:0]      r_sx;
    logic [2*CW-1:0]      r_sy;

    logic                 r_s3_vld;
    logic                 r_s3_keep;
    logic [AW-1:0]        r_s3_idx;
    logic [gnps_pkg::DIST_W-1:0] r_sum;

    // sign-extended differences, magnitude fits in CW bits
    assign dxw = {i_px[CW-1], i_px} - {i_qx[CW-1], i_qx};
    assign dyw = {i_py[CW-1], i_py} - {i_qy[CW-1], i_qy};
    assign dxa = dxw[CW] ? ((CW+1)'(0) - dxw) : dxw;
    assign dya = dyw[CW] ? ((CW+1)'(0) - dyw) : dyw;

    assign gate_hit = i_range_mode &&
                      (((i_x_limit != '0) && (r_dx > i_x_limit)) ||
                       ((i_y_limit != '0) && (r_dy > i_y_limit)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_idx;
        r_dx      <= dxa[CW-1:0];
        r_dy      <= dya[CW-1:0];

        r_s2_idx  <= r_s1_idx;
        r_s2_keep <= !gate_hit;
        r_sx      <= r_dx * r_dx;
        r_sy      <= r_dy * r_dy;

        r_s3_idx  <= r_s2_idx;
        r_s3_keep <= r_s2_keep;
        r_sum     <= {1'b0, r_sx} + {1'b0, r_sy};
    end

    assign o_tag.vld  = r_s3_vld;
    assign o_tag.keep = r_s3_keep;
    assign o_idx      = r_s3_idx;
    assign o_dist     = r_sum;
    assign o_busy     = r_s1_vld || r_s2_vld || r_s3_vld;

endmodule

>>> hw/rtl/gated_nearest_point_search_unit.sv
// top level of the gated nearest point search unit
// A load, a clear or an unused command passes its result through S_PUT to the output register.
// A query reads the point memory once per stored point, one entry per cycle through its single
// read port; the entries pass the registered read, a three-stage distance pipeline and the
// compare before the result goes to the output register, and a query on an empty table goes
// straight to S_PUT. One command is in flight at a time; a new command is taken while the
// previous result still waits in the output register. Coordinates live in one memory of
// MAX_POINTS entries with no reset and no clearing pass; only the point count is cleared.
module gated_nearest_point_search_unit #(
    parameter int unsigned MAX_POINTS = gnps_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gnps_pkg::t_in_beat            i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gnps_pkg::t_out_beat           o_out_beat,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [gnps_pkg::COORD_W-1:0]  i_cfg_data
);

    localparam int unsigned AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNW = $clog2(MAX_POINTS + 1);
    localparam int unsigned PW  = 2 * gnps_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PUT   = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [CNW-1:0]                 r_count, n_count;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [AW-1:0]                  r_last, n_last;
    gnps_pkg::t_out_beat            r_res, n_res;
    gnps_pkg::t_out_beat            r_out, n_out;
    logic                           r_out_vld, n_out_vld;

    logic                           r_range_mode;
    logic [gnps_pkg::COORD_W-1:0]   r_x_limit;
    logic [gnps_pkg::COORD_W-1:0]   r_y_limit;

    logic [gnps_pkg::COORD_W-1:0]   r_qx;
    logic [gnps_pkg::COORD_W-1:0]   r_qy;

    logic [PW-1:0]                  mem [MAX_POINTS];
    logic [PW-1:0]                  r_rd_data;
    logic                           r_rd_vld;
    logic [AW-1:0]                  r_rd_idx;

    logic                           r_found;
    logic [gnps_pkg::DIST_W-1:0]    r_best_d;
    logic [AW-1:0]                  r_best_idx;

    logic                           in_acc;
    logic                           is_full;
    logic                           mem_we;
    logic                           q_start;
    logic                           best_upd;

    gnps_pkg::t_cand                pipe_tag;
    logic [AW-1:0]                  pipe_idx;
    logic [gnps_pkg::DIST_W-1:0]    pipe_dist;
    logic                           pipe_busy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign is_full     = (r_count >= CNW'(MAX_POINTS));
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_last    = r_last;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        mem_we    = 1'b0;
        q_start   = 1'b0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PUT;
                    n_res   = '0;
                    case (i_in_beat.cmd)
                        gnps_pkg::CMD_LOAD: begin
                            if (is_full) begin
                                n_res.status = gnps_pkg::ST_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                n_res.point_index = gnps_pkg::IDX_W'(r_count);
                                n_count           = r_count + CNW'(1);
                            end
                        end
                        gnps_pkg::CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_res.status = gnps_pkg::ST_NOMATCH;
                            end else begin
                                q_start = 1'b1;
                                n_state = S_SCAN;
                                n_addr  = '0;
                                n_last  = AW'(r_count - CNW'(1));
                            end
                        end
                        gnps_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !pipe_busy) begin
                    n_state = S_PUT;
                    if (r_found) begin
                        n_res.status      = gnps_pkg::ST_OK;
                        n_res.point_index = gnps_pkg::IDX_W'(r_best_idx);
                    end else begin
                        n_res.status      = gnps_pkg::ST_NOMATCH;
                        n_res.point_index = '0;
                    end
                end
            end
            S_PUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_vld    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_range_mode <= 1'b0;
            r_x_limit    <= gnps_pkg::LIMIT_RST;
            r_y_limit    <= gnps_pkg::LIMIT_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_state == S_SCAN);
            if (q_start) begin
                r_found <= 1'b0;
            end else if (best_upd) begin
                r_found <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gnps_pkg::CFG_RANGE_MODE: r_range_mode <= i_cfg_data[0];
                    gnps_pkg::CFG_X_LIMIT:    r_x_limit    <= i_cfg_data;
                    gnps_pkg::CFG_Y_LIMIT:    r_y_limit    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_last <= n_last;
        r_res  <= n_res;
        r_out  <= n_out;
        if (q_start) begin
            r_qx <= i_in_beat.x_coord;
            r_qy <= i_in_beat.y_coord;
        end
        if (best_upd) begin
            r_best_d   <= pipe_dist;
            r_best_idx <= pipe_idx;
        end
    end

    // point memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= {i_in_beat.x_coord, i_in_beat.y_coord};
        end
        r_rd_data <= mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    gnps_dist_pipe #(
        .AW (AW)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_rd_vld),
        .i_idx        (r_rd_idx),
        .i_px         (r_rd_data[PW-1:gnps_pkg::COORD_W]),
        .i_py         (r_rd_data[gnps_pkg::COORD_W-1:0]),
        .i_qx         (r_qx),
        .i_qy         (r_qy),
        .i_range_mode (r_range_mode),
        .i_x_limit    (r_x_limit),
        .i_y_limit    (r_y_limit),
        .o_tag        (pipe_tag),
        .o_idx        (pipe_idx),
        .o_dist       (pipe_dist),
        .o_busy       (pipe_busy)
    );

    // strict less-than keeps the first index on a tie
    assign best_upd = pipe_tag.vld && pipe_tag.keep && (!r_found || (pipe_dist < r_best_d));

endmodule

>>> hw/rtl/gnps_checker.sv
// port-level checker of the gated nearest point search unit and its bind
module gnps_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  gnps_pkg::t_out_beat  o_out_beat
);

    // a result beat waits unchanged until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // one command in flight: no accept right after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command accepted while another is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.status == gnps_pkg::ST_OK) ||
                        (o_out_beat.status == gnps_pkg::ST_FULL) ||
                        (o_out_beat.status == gnps_pkg::ST_NOMATCH))
        else $error("unknown status code");

    // dropped loads and misses report index zero
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != gnps_pkg::ST_OK) |-> o_out_beat.point_index == '0)
        else $error("nonzero index on a failed command");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("unit not idle after reset");

endmodule

bind gated_nearest_point_search_unit gnps_checker u_gnps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
